// ===== sv/mpf_pkg.sv =====
// mpf_pkg: shared types and constants for the page-organized monochrome frame buffer
// used by every module of the block; no dependencies
package mpf_pkg;

    localparam int unsigned DEF_PANEL_WIDTH  = 128;
    localparam int unsigned DEF_PANEL_HEIGHT = 64;

    localparam logic [7:0] FILL_BLACK = 8'h00;
    localparam logic [7:0] FILL_WHITE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_FILL  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RMW_RD,
        S_RMW_WR,
        S_READ,
        S_READ_OUT
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ===== sv/mpf_alu.sv =====
// mpf_alu: shared address and bit-update unit, used once per column of a draw
// depends on mpf_pkg
module mpf_alu
    import mpf_pkg::*;
#(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic [$clog2(PANEL_WIDTH*((PANEL_HEIGHT+7)/8))-1:0] i_base,
    input  logic [7:0]                                          i_col,
    input  logic [2:0]                                          i_bit,
    input  logic                                                i_white,
    input  logic [7:0]                                          i_byte,
    output logic [$clog2(PANEL_WIDTH*((PANEL_HEIGHT+7)/8))-1:0] o_addr,
    output logic [7:0]                                          o_byte
);

    localparam int unsigned STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
    localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

    logic [7:0] mask;

    assign o_addr = i_base + ADDR_W'(i_col);
    assign mask   = 8'd1 << i_bit;
    assign o_byte = i_white ? (i_byte | mask) : (i_byte & ~mask);

endmodule

// ===== sv/mpf_store.sv =====
// mpf_store: frame byte memory, with one address shared by the write and the registered read
// depends on mpf_pkg
module mpf_store
    import mpf_pkg::*;
#(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic                                                i_clk,
    input  t_mem_ctl                                            i_ctl,
    input  logic [$clog2(PANEL_WIDTH*((PANEL_HEIGHT+7)/8))-1:0] i_addr,
    input  logic [7:0]                                          i_wr_data,
    output logic [7:0]                                          o_rd_data
);

    localparam int unsigned STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/mpf_ctrl.sv =====
// mpf_ctrl: command sequencer, clear/fill sweep, column walk and result register
// depends on mpf_pkg; drives mpf_store and uses mpf_alu results
module mpf_ctrl
    import mpf_pkg::*;
#(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_in_valid,
    output logic                                                o_in_ready,
    input  logic [1:0]                                          i_command,
    input  logic [7:0]                                          i_x_start,
    input  logic [7:0]                                          i_x_end,
    input  logic [7:0]                                          i_row,
    input  logic [2:0]                                          i_page,
    input  logic                                                i_color,
    input  logic                                                i_invert_this,
    input  logic                                                i_global_invert_we,
    input  logic                                                i_global_invert,
    output logic                                                o_out_valid,
    input  logic                                                i_out_ready,
    output logic [7:0]                                          o_read_data,
    output t_mem_ctl                                            o_mem_ctl,
    output logic [$clog2(PANEL_WIDTH*((PANEL_HEIGHT+7)/8))-1:0] o_mem_addr,
    output logic [7:0]                                          o_mem_wr_data,
    input  logic [7:0]                                          i_mem_rd_data,
    output logic [$clog2(PANEL_WIDTH*((PANEL_HEIGHT+7)/8))-1:0] o_alu_base,
    output logic [7:0]                                          o_alu_col,
    output logic [2:0]                                          o_alu_bit,
    output logic                                                o_alu_white,
    input  logic [$clog2(PANEL_WIDTH*((PANEL_HEIGHT+7)/8))-1:0] i_alu_addr,
    input  logic [7:0]                                          i_alu_byte
);

    localparam int unsigned PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
    localparam int unsigned STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
    localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] CNT_LAST = ADDR_W'(STORE_BYTES - 1);
    localparam logic [7:0]        COL_MAX  = 8'(PANEL_WIDTH - 1);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [7:0]        r_fill_byte, n_fill_byte;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [7:0]        r_col, n_col;
    logic [7:0]        r_last, n_last;
    logic [2:0]        r_bit, n_bit;
    logic              r_white, n_white;
    logic              r_oor, n_oor;
    logic              r_invert;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_data, n_out_data;

    t_cmd        cmd;
    logic        accept;
    logic        col_ok;
    logic        row_ok;
    logic        page_ok;
    logic [7:0]  line_last;
    logic [7:0]  draw_last;
    logic [2:0]  sel_page;
    logic [11:0] base_full;
    logic        load_out;

    assign cmd        = t_cmd'(i_command);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign col_ok    = {1'b0, i_x_start} < 9'(PANEL_WIDTH);
    assign row_ok    = {1'b0, i_row} < 9'(PANEL_HEIGHT);
    assign page_ok   = {1'b0, i_page} < 4'(PAGE_COUNT);
    assign line_last = ({1'b0, i_x_end} > 9'(PANEL_WIDTH - 1)) ? COL_MAX : i_x_end;
    assign draw_last = (cmd == CMD_LINE) ? line_last : i_x_start;
    // with the default height rows reach at most 63, so the page of a row is bits 5:3
    assign sel_page  = (cmd == CMD_READ) ? i_page : i_row[5:3];
    assign base_full = 12'(sel_page) * 12'(PANEL_WIDTH);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_FILL: n_state = S_CLEAR;
                        CMD_READ: n_state = S_READ;
                        default: begin
                            if (col_ok && row_ok && (i_x_start <= draw_last)) begin
                                n_state = S_RMW_RD;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_RMW_RD:   n_state = S_RMW_WR;
            S_RMW_WR: begin
                n_state = (r_col == r_last) ? S_IDLE : S_RMW_RD;
            end
            S_READ:     n_state = S_READ_OUT;
            S_READ_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // memory and result outputs
    always_comb begin
        o_mem_ctl     = '0;
        o_mem_addr    = i_alu_addr;
        o_mem_wr_data = i_alu_byte;
        load_out      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_addr      = r_cnt;
                o_mem_wr_data   = r_fill_byte;
            end
            S_RMW_RD:   o_mem_ctl.rd_en = 1'b1;
            S_RMW_WR:   o_mem_ctl.wr_en = 1'b1;
            S_READ:     o_mem_ctl.rd_en = !r_oor;
            S_READ_OUT: load_out = !r_out_valid || i_out_ready;
            default:    o_mem_ctl = '0;
        endcase
    end

    // datapath registers
    always_comb begin
        n_cnt       = r_cnt;
        n_fill_byte = r_fill_byte;
        n_base      = r_base;
        n_col       = r_col;
        n_last      = r_last;
        n_bit       = r_bit;
        n_white     = r_white;
        n_oor       = r_oor;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (accept) begin
            n_cnt       = '0;
            n_fill_byte = i_color ? FILL_WHITE : FILL_BLACK;
            n_base      = ADDR_W'(base_full);
            n_col       = i_x_start;
            n_last      = draw_last;
            n_bit       = i_row[2:0];
            n_white     = i_color ^ (i_invert_this | r_invert);
            n_oor       = !(page_ok && col_ok);
        end
        if (r_state == S_CLEAR) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (r_state == S_RMW_WR) begin
            n_col = r_col + 1'b1;
        end

        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_data  = r_oor ? FILL_BLACK : i_mem_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset starts a black clearing sweep
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_fill_byte <= FILL_BLACK;
            r_invert    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill_byte <= n_fill_byte;
            r_out_valid <= n_out_valid;
            if (i_global_invert_we) begin
                r_invert <= i_global_invert;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_col      <= n_col;
        r_last     <= n_last;
        r_bit      <= n_bit;
        r_white    <= n_white;
        r_oor      <= n_oor;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_alu_base  = r_base;
    assign o_alu_col   = r_col;
    assign o_alu_bit   = r_bit;
    assign o_alu_white = r_white;

endmodule

// ===== sv/monochrome_page_framebuffer.sv =====
// a pixel is one memory read-modify-write (S_RMW_RD, then S_RMW_WR), a line one per drawn
// column; an ignored pixel or empty line never leaves S_IDLE; a read passes S_READ and
// S_READ_OUT and loads the result register there once it is free or being taken; a fill writes
// all PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes. Reset (synchronous, active low) starts a clearing
// sweep of those bytes during which no item is taken; configuration writes are taken outside reset
// depends on mpf_pkg, mpf_alu, mpf_store, mpf_ctrl
module monochrome_page_framebuffer
    import mpf_pkg::*;
#(
    parameter int unsigned PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_x_start,
    input  logic [7:0] i_x_end,
    input  logic [7:0] i_row,
    input  logic [2:0] i_page,
    input  logic       i_color,
    input  logic       i_invert_this,
    input  logic       i_global_invert_we,
    input  logic       i_global_invert,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data
);

    localparam int unsigned STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
    localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

    t_mem_ctl          mem_ctl;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wr_data;
    logic [7:0]        mem_rd_data;
    logic [ADDR_W-1:0] alu_base;
    logic [7:0]        alu_col;
    logic [2:0]        alu_bit;
    logic              alu_white;
    logic [ADDR_W-1:0] alu_addr;
    logic [7:0]        alu_byte;

    mpf_ctrl #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_x_start          (i_x_start),
        .i_x_end            (i_x_end),
        .i_row              (i_row),
        .i_page             (i_page),
        .i_color            (i_color),
        .i_invert_this      (i_invert_this),
        .i_global_invert_we (i_global_invert_we),
        .i_global_invert    (i_global_invert),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_read_data        (o_read_data),
        .o_mem_ctl          (mem_ctl),
        .o_mem_addr         (mem_addr),
        .o_mem_wr_data      (mem_wr_data),
        .i_mem_rd_data      (mem_rd_data),
        .o_alu_base         (alu_base),
        .o_alu_col          (alu_col),
        .o_alu_bit          (alu_bit),
        .o_alu_white        (alu_white),
        .i_alu_addr         (alu_addr),
        .i_alu_byte         (alu_byte)
    );

    mpf_alu #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_alu (
        .i_base  (alu_base),
        .i_col   (alu_col),
        .i_bit   (alu_bit),
        .i_white (alu_white),
        .i_byte  (mem_rd_data),
        .o_addr  (alu_addr),
        .o_byte  (alu_byte)
    );

    mpf_store #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

endmodule

// ===== sv/mpf_checker.sv =====
// mpf_checker: port-level assertions for the frame buffer, bound to the top level
// depends on mpf_pkg and monochrome_page_framebuffer
module mpf_checker
    import mpf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_command,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_data
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data))
        else $error("result changed or dropped while stalled");

    // reset always starts the clearing sweep
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("ready right after reset");

    // fill and read always occupy the sequencer
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready
        && (t_cmd'(i_command) == CMD_FILL || t_cmd'(i_command) == CMD_READ)
        |=> !o_in_ready)
        else $error("ready right after fill or read item");

    // a read with a free result register shows its result after the S_READ and S_READ_OUT states
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && t_cmd'(i_command) == CMD_READ && !o_out_valid
        |=> ##2 o_out_valid)
        else $error("read result late");

endmodule

bind monochrome_page_framebuffer mpf_checker u_mpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_read_data (o_read_data)
);

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for the page-organized monochrome frame buffer
// keeps its own copy of the frame bytes, predicts every read-back and checks it in order
// depends on mpf_pkg and monochrome_page_framebuffer
`timescale 1ns / 100ps

module tb_top;
    import mpf_pkg::*;

    localparam int PANEL_W     = DEF_PANEL_WIDTH;
    localparam int PANEL_H     = DEF_PANEL_HEIGHT;
    localparam int PAGES       = (PANEL_H + 7) / 8;
    localparam int STORE_BYTES = PANEL_W * PAGES;
    // a fill walks the whole store, so that bounds how long a silent command can run
    localparam int SETTLE_CYCLES = STORE_BYTES + 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 125;
    localparam int CYCLE_LIMIT   = 3000000;

    class page_store_scoreboard;
        logic [7:0] frame [STORE_BYTES];
        bit         invert_reg;
        logic [7:0] read_q [$];
        int         errors;

        function new();
            foreach (frame[i]) frame[i] = FILL_BLACK;
            invert_reg = 1'b0;
            errors     = 0;
        endfunction

        function void set_invert(bit v);
            invert_reg = v;
        endfunction

        function int pending();
            return read_q.size();
        endfunction

        function void plot(int col, int rw, bit white);
            int idx;
            if (col >= PANEL_W || rw >= PANEL_H) return;
            idx = col + (rw / 8) * PANEL_W;
            frame[idx][rw % 8] = white;
        endfunction

        function void note_item(t_cmd cmd, logic [7:0] xs, logic [7:0] xe, logic [7:0] rw,
                                logic [2:0] pg, logic color, logic inv);
            bit white;
            white = color ^ (inv | invert_reg);
            case (cmd)
                CMD_FILL: begin
                    // inversion never applies to a fill
                    foreach (frame[i]) frame[i] = color ? FILL_WHITE : FILL_BLACK;
                end
                CMD_PIXEL: plot(xs, rw, white);
                CMD_LINE: begin
                    for (int c = xs; c <= xe; c++) plot(c, rw, white);
                end
                default: begin
                    if (pg < PAGES && xs < PANEL_W)
                        read_q.push_back(frame[xs + pg * PANEL_W]);
                    else
                        read_q.push_back(8'h00);
                end
            endcase
        endfunction

        function void flag(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s expected %02h got %02h", $time, what, want, got);
        endfunction

        function void check_read(logic [7:0] got);
            logic [7:0] want;
            if (read_q.size() == 0) begin
                flag("read_data with no read outstanding,", 8'h00, got);
            end else begin
                want = read_q.pop_front();
                if (got !== want) flag("read_data", want, got);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_cmd       cmd;
    logic [7:0] x_start;
    logic [7:0] x_end;
    logic [7:0] row;
    logic [2:0] page;
    logic       color;
    logic       invert_this;
    logic       invert_we;
    logic       invert_val;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_data;

    page_store_scoreboard sb;

    bit         hold_off_req;
    bit         no_gaps;
    int         gap_left;
    int         gap_mode;
    logic [7:0] last_x;
    logic [7:0] last_row;
    longint     cycles;

    monochrome_page_framebuffer uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_command          (cmd),
        .i_x_start          (x_start),
        .i_x_end            (x_end),
        .i_row              (row),
        .i_page             (page),
        .i_color            (color),
        .i_invert_this      (invert_this),
        .i_global_invert_we (invert_we),
        .i_global_invert    (invert_val),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_read_data        (read_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // results are checked before the new item is noted; a result always belongs to an older read
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_read(read_data);
            if (in_valid && in_ready)
                sb.note_item(cmd, x_start, x_end, row, page, color, invert_this);
        end
    end

    // receiver side: runs of steady ready, random ready and stalls, plus one long hold-off
    initial begin
        int run_left;
        int mode;
        run_left = 0;
        mode     = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode     = $urandom_range(0, 9);
                    run_left = (mode == 9) ? $urandom_range(20, 60) : $urandom_range(1, 50);
                end
                run_left--;
                if (mode < 4)
                    out_ready = 1'b1;
                else if (mode < 9)
                    out_ready = ($urandom_range(0, 99) < 75);
                else
                    out_ready = 1'b0;
            end
        end
    end

    function automatic int next_gap();
        int r;
        if (no_gaps) return 0;
        if (gap_left == 0) begin
            gap_left = $urandom_range(1, 40);
            gap_mode = $urandom_range(0, 3);
        end
        gap_left--;
        if (gap_mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 3) return $urandom_range(20, 80);
        if (r < 40) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic send_item(t_cmd c, logic [7:0] xs, logic [7:0] xe, logic [7:0] rw,
                             logic [2:0] pg, logic col, logic inv);
        int gap;
        gap = next_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd         = c;
        x_start     = xs;
        x_end       = xe;
        row         = rw;
        page        = pg;
        color       = col;
        invert_this = inv;
        in_valid    = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // lets every outstanding read come back and any silent command finish
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_invert(bit v);
        @(negedge clk);
        invert_we  = 1'b1;
        invert_val = v;
        sb.set_invert(v);
        @(negedge clk);
        invert_we = 1'b0;
    endtask

    task automatic random_item();
        int         pick;
        int         shape;
        int         stop;
        t_cmd       c;
        logic [7:0] xs;
        logic [7:0] xe;
        logic [7:0] rw;
        logic [2:0] pg;
        pick = $urandom_range(0, 99);
        xs = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, PANEL_W - 1))
                                          : 8'($urandom_range(0, 255));
        rw = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, PANEL_H - 1))
                                          : 8'($urandom_range(0, 255));
        xe = 8'($urandom_range(0, 255));
        pg = 3'($urandom_range(0, 7));
        if (pick < 4) begin
            c = CMD_FILL;
        end else if (pick < 38) begin
            c = CMD_PIXEL;
        end else if (pick < 62) begin
            c = CMD_LINE;
            shape = $urandom_range(0, 99);
            // mostly short runs, a few to the right edge or with a random end
            if (shape < 80) begin
                stop = xs + $urandom_range(0, 15);
                xe = (stop > 255) ? 8'd255 : 8'(stop);
            end else if (shape < 90) begin
                xe = 8'd255;
            end
        end else begin
            c = CMD_READ;
            if ($urandom_range(0, 1) == 1) begin
                xs = last_x;
                pg = last_row[5:3];
            end
        end
        if (c == CMD_PIXEL || c == CMD_LINE) begin
            last_x   = xs;
            last_row = rw;
        end
        send_item(c, xs, xe, rw, pg, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_FILL;
        x_start      = 8'h00;
        x_end        = 8'h00;
        row          = 8'h00;
        page         = 3'd0;
        color        = 1'b0;
        invert_this  = 1'b0;
        invert_we    = 1'b0;
        invert_val   = 1'b0;
        hold_off_req = 1'b0;
        no_gaps      = 1'b0;
        gap_left     = 0;
        gap_mode     = 0;
        last_x       = 8'h00;
        last_row     = 8'h00;
        cycles       = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_invert(1'b0);

        // directed: corners, clipping, empty lines, out-of-range reads, fills
        send_item(CMD_READ,  8'd0,   8'd0,   8'd0,   3'd0, 1'b0, 1'b0);
        send_item(CMD_PIXEL, 8'd0,   8'd0,   8'd0,   3'd0, 1'b1, 1'b0);
        send_item(CMD_READ,  8'd0,   8'd0,   8'd0,   3'd0, 1'b0, 1'b0);
        send_item(CMD_PIXEL, 8'd127, 8'd0,   8'd63,  3'd0, 1'b1, 1'b0);
        send_item(CMD_READ,  8'd127, 8'd255, 8'd255, 3'd7, 1'b1, 1'b1);
        send_item(CMD_PIXEL, 8'd128, 8'd0,   8'd0,   3'd0, 1'b1, 1'b0);
        send_item(CMD_PIXEL, 8'd255, 8'd0,   8'd64,  3'd0, 1'b1, 1'b0);
        send_item(CMD_PIXEL, 8'd0,   8'd0,   8'd0,   3'd0, 1'b1, 1'b1);
        send_item(CMD_READ,  8'd0,   8'd0,   8'd0,   3'd0, 1'b0, 1'b0);
        send_item(CMD_LINE,  8'd120, 8'd255, 8'd8,   3'd0, 1'b1, 1'b0);
        send_item(CMD_READ,  8'd127, 8'd0,   8'd0,   3'd1, 1'b0, 1'b0);
        send_item(CMD_LINE,  8'd10,  8'd5,   8'd0,   3'd0, 1'b1, 1'b0);
        send_item(CMD_LINE,  8'd0,   8'd255, 8'd200, 3'd0, 1'b1, 1'b0);
        send_item(CMD_READ,  8'd7,   8'd0,   8'd0,   3'd0, 1'b0, 1'b0);
        send_item(CMD_READ,  8'd200, 8'd0,   8'd0,   3'd3, 1'b0, 1'b0);
        send_item(CMD_FILL,  8'd0,   8'd0,   8'd0,   3'd0, 1'b1, 1'b1);
        send_item(CMD_PIXEL, 8'd60,  8'd0,   8'd40,  3'd0, 1'b0, 1'b0);
        send_item(CMD_READ,  8'd60,  8'd0,   8'd0,   3'd5, 1'b0, 1'b0);
        send_item(CMD_FILL,  8'd0,   8'd0,   8'd0,   3'd0, 1'b0, 1'b0);
        settle();

        // global invert: fill unaffected, both inversions together invert only once
        write_invert(1'b1);
        send_item(CMD_FILL,  8'd0,   8'd0,   8'd0,   3'd0, 1'b0, 1'b0);
        send_item(CMD_PIXEL, 8'd3,   8'd0,   8'd17,  3'd0, 1'b0, 1'b0);
        send_item(CMD_PIXEL, 8'd4,   8'd0,   8'd17,  3'd0, 1'b1, 1'b1);
        send_item(CMD_LINE,  8'd0,   8'd2,   8'd17,  3'd0, 1'b0, 1'b1);
        send_item(CMD_READ,  8'd3,   8'd0,   8'd0,   3'd2, 1'b0, 1'b0);
        send_item(CMD_READ,  8'd0,   8'd0,   8'd0,   3'd2, 1'b0, 1'b0);

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            write_invert(ph % 2 == 1);
            if (ph == 2) begin
                // reads back to back while the result side is held off
                hold_off_req = 1'b1;
                no_gaps      = 1'b1;
                for (int k = 0; k < 30; k++)
                    send_item(CMD_READ, 8'($urandom_range(0, 255)), 8'd0, 8'd0,
                              3'($urandom_range(0, 7)), 1'b0, 1'b0);
                no_gaps = 1'b0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) random_item();
        end
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
